>>> sv/etmc_pkg.sv
// ----------------------------------------------------------------------------
// etmc_pkg: shared types, codes and ROMs of the escaped text converter
// Holds the channel words, the parser mode type, the error codes and the
// character, code and escape ROMs.
// ----------------------------------------------------------------------------
package etmc_pkg;

  // Character constants seen by the parser.
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BSL   = 8'h5c;

  // Machine code of the end-of-data record; it also closes a record.
  localparam logic [7:0] CODE_EOD = 8'h0a;

  // Error codes carried in the result word.
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_ESCAPE   = 3'd1;
  localparam logic [2:0] ERR_STRING   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_OPEN   = 3'd1,
    M_CODE   = 3'd2,
    M_BSL    = 3'd3,
    M_ESC    = 3'd4,
    M_SKIP   = 3'd5,
    M_HALT   = 3'd6
  } mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    logic [7:0] code;
    logic [6:0] position;
    logic       line_end;
    logic [6:0] fill_count;
    logic [2:0] error;
  } out_word_t;

  // Result words produced for one accepted input word.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

  // Machine code of a plain text byte; unmapped bytes give zero.
  function automatic logic [7:0] plain_map(input logic [7:0] c);
    logic [7:0] t;
    unique case (c)
      8'h2d: t = 8'h00;  8'h79: t = 8'h01;  8'h20: t = 8'h03;  8'h08: t = 8'h13;
      8'h71: t = 8'h04;  8'h70: t = 8'h05;  8'h3d: t = 8'h06;  8'h6a: t = 8'h07;
      8'h2f: t = 8'h09;  8'h2c: t = 8'h8c;  8'h66: t = 8'h0e;  8'h67: t = 8'h0f;
      8'h77: t = 8'h10;  8'h73: t = 8'h11;  8'h69: t = 8'h14;  8'h27: t = 8'h15;
      8'h2e: t = 8'h96;  8'h5b: t = 8'h17;  8'h0a: t = 8'h33;  8'h6f: t = 8'h19;
      8'h09: t = 8'h23;  8'h61: t = 8'h1c;  8'h72: t = 8'h1d;  8'h76: t = 8'h1e;
      8'h6d: t = 8'h1f;  8'h62: t = 8'h20;  8'h68: t = 8'h21;  8'h6b: t = 8'h24;
      8'h65: t = 8'h25;  8'h6e: t = 8'h26;  8'h74: t = 8'h27;  8'h6c: t = 8'h29;
      8'h63: t = 8'h2c;  8'h64: t = 8'h2d;  8'h75: t = 8'h2e;  8'h78: t = 8'h2f;
      8'h39: t = 8'h30;  8'h30: t = 8'h31;  8'h36: t = 8'h34;  8'h35: t = 8'h35;
      8'h32: t = 8'h36;  8'h7a: t = 8'h37;  8'h34: t = 8'h39;  8'h38: t = 8'h3c;
      8'h37: t = 8'h3d;  8'h33: t = 8'h3e;  8'h31: t = 8'h3f;
      8'h5f: t = 8'h80;  8'h59: t = 8'h81;  8'h51: t = 8'h84;  8'h50: t = 8'h85;
      8'h2b: t = 8'h86;  8'h4a: t = 8'h87;  8'h3f: t = 8'h89;  8'h3a: t = 8'h8d;
      8'h46: t = 8'h8e;  8'h47: t = 8'h8f;  8'h57: t = 8'h90;  8'h53: t = 8'h91;
      8'h7c: t = 8'h92;  8'h49: t = 8'h94;  8'h22: t = 8'h95;  8'h7b: t = 8'h97;
      8'h4f: t = 8'h99;  8'h41: t = 8'h9c;  8'h52: t = 8'h9d;  8'h56: t = 8'h9e;
      8'h4d: t = 8'h9f;  8'h42: t = 8'ha0;  8'h48: t = 8'ha1;  8'h4b: t = 8'ha4;
      8'h45: t = 8'ha5;  8'h4e: t = 8'ha6;  8'h54: t = 8'ha7;  8'h4c: t = 8'ha9;
      8'h43: t = 8'hac;  8'h44: t = 8'had;  8'h55: t = 8'hae;  8'h58: t = 8'haf;
      8'h28: t = 8'hb0;  8'h29: t = 8'hb1;  8'h5e: t = 8'hb4;  8'h25: t = 8'hb5;
      8'h40: t = 8'hb6;  8'h5a: t = 8'hb7;  8'h24: t = 8'hb9;  8'h2a: t = 8'hbc;
      8'h26: t = 8'hbd;  8'h23: t = 8'hbe;  8'h21: t = 8'hbf;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  // Machine code selected by a bracketed code character; zero means unknown.
  function automatic logic [7:0] code_map(input logic [7:0] c);
    logic [7:0] t;
    unique case (c)
      8'h20: t = 8'h02;  8'h08: t = 8'h12;  8'h09: t = 8'h22;  8'h0a: t = 8'h32;
      8'h2d: t = 8'h08;  8'h77: t = 8'h18;  8'h62: t = 8'h28;  8'h39: t = 8'h38;
      8'h2f: t = 8'h0a;  8'h6f: t = 8'h1a;  8'h6c: t = 8'h2a;  8'h34: t = 8'h3a;
      8'h67: t = 8'h0b;  8'h6d: t = 8'h1b;  8'h78: t = 8'h2b;  8'h31: t = 8'h3b;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  // Escape letter to control character, either case; zero means bad escape.
  function automatic logic [7:0] escape_map(input logic [7:0] e);
    logic [7:0] t;
    unique case (e) inside
      8'h62, 8'h42: t = 8'h08;
      8'h6e, 8'h4e: t = 8'h0a;
      8'h74, 8'h54: t = 8'h09;
      default:      t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

>>> sv/etmc_parse.sv
// ----------------------------------------------------------------------------
// etmc_parse: text parser and line position tracker
// Holds the parser state and turns each accepted word into zero, one or two
// result words for the output queue.
// ----------------------------------------------------------------------------
module etmc_parse
  import etmc_pkg::*;
#(
  parameter int LINE_LEN = 100
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_word_t in_word,
  output push_t    push
);

  localparam logic [6:0] LAST_POS = 7'(LINE_LEN - 1);

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic       eod_r, eod_nxt;

  logic       do_close, do_emit, em_raw, set_eod;
  logic [7:0] em_c, em_t, esc_c, close_t;
  logic       fail_now, emit_ok, emit_close, eoi, eoi_mid;
  logic [2:0] fail_err;

  assign esc_c   = escape_map(in_word.ch);
  assign close_t = code_map(held_r);

  // Next state and the decision of what, if anything, goes out.
  always_comb begin
    mode_nxt   = mode_r;
    held_nxt   = held_r;
    pos_nxt    = pos_r;
    eod_nxt    = eod_r;
    do_close   = 1'b0;
    do_emit    = 1'b0;
    em_raw     = 1'b0;
    em_c       = 8'h00;
    em_t       = 8'h00;
    set_eod    = 1'b0;
    fail_now   = 1'b0;
    fail_err   = ERR_OK;
    emit_ok    = 1'b0;
    emit_close = 1'b0;
    eoi        = 1'b0;
    eoi_mid    = 1'b0;
    if (in_fire && in_word.func) begin
      // End of input: flush an open line as an error, then return to reset.
      eoi      = 1'b1;
      eoi_mid  = (mode_r == M_OPEN) || (mode_r == M_CODE) || (mode_r == M_BSL) ||
                 (mode_r == M_ESC) || ((mode_r == M_NORMAL) && (pos_r != 7'd0));
      mode_nxt = M_NORMAL;
      held_nxt = 8'h00;
      pos_nxt  = 7'd0;
      eod_nxt  = 1'b0;
    end else if (in_fire) begin
      unique case (mode_r)
        M_NORMAL: begin
          eod_nxt = 1'b0;
          if (in_word.ch == CH_LBRK) begin
            mode_nxt = M_OPEN;
          end else begin
            do_emit = 1'b1;
            em_c    = in_word.ch;
            em_t    = plain_map(in_word.ch);
            em_raw  = 1'b1;
          end
        end
        M_OPEN: begin
          if (in_word.ch == CH_LF) begin
            fail_now = 1'b1;
            fail_err = ERR_STRING;
          end else begin
            held_nxt = in_word.ch;
            mode_nxt = M_CODE;
          end
        end
        M_CODE: begin
          if (in_word.ch == CH_BSL) begin
            mode_nxt = M_BSL;
          end else begin
            do_close = 1'b1;
          end
        end
        M_BSL: begin
          if (esc_c == 8'h00) begin
            fail_now = 1'b1;
            fail_err = ERR_ESCAPE;
          end else begin
            held_nxt = esc_c;
            mode_nxt = M_ESC;
          end
        end
        M_ESC: begin
          do_close = 1'b1;
        end
        M_SKIP: begin
          if (in_word.ch == CH_LF) begin
            mode_nxt = M_NORMAL;
          end
        end
        M_HALT: begin
        end
        default: begin
        end
      endcase

      // Closing bracket of a code sequence.
      if (do_close) begin
        if (in_word.ch != CH_RBRK) begin
          fail_now = 1'b1;
          fail_err = ERR_STRING;
        end else if (close_t == 8'h00) begin
          fail_now = 1'b1;
          fail_err = ERR_UNKNOWN;
        end else begin
          held_nxt = 8'h00;
          do_emit  = 1'b1;
          set_eod  = (held_r == CH_SLASH);
          em_c     = (held_r == CH_SLASH) ? CH_LF : held_r;
          em_t     = close_t;
        end
      end

      // Place the code in the record, closing it on a newline.
      if (do_emit) begin
        if ((em_c == CH_LF) || (em_t == CODE_EOD)) begin
          if (em_c != CH_LF) begin
            fail_now = 1'b1;
            fail_err = ERR_OVERFLOW;
          end else begin
            emit_ok    = 1'b1;
            emit_close = 1'b1;
            pos_nxt    = 7'd0;
            mode_nxt   = em_raw ? M_NORMAL : M_SKIP;
          end
        end else if (pos_r >= LAST_POS) begin
          fail_now = 1'b1;
          fail_err = ERR_OVERFLOW;
        end else begin
          emit_ok  = 1'b1;
          pos_nxt  = pos_r + 7'd1;
          mode_nxt = M_NORMAL;
        end
      end

      if (fail_now) begin
        mode_nxt = M_HALT;
        eod_nxt  = 1'b0;
        pos_nxt  = 7'd0;
        held_nxt = 8'h00;
      end else if (set_eod) begin
        eod_nxt = 1'b1;
      end
    end
  end

  // Result words.
  always_comb begin
    out_word_t fail_w, eod_w, emit_w;
    fail_w = '{code: 8'h00, position: pos_r, line_end: 1'b1,
               fill_count: 7'd0, error: ERR_OVERFLOW};
    eod_w  = '{code: CODE_EOD, position: 7'd0, line_end: 1'b1,
               fill_count: LAST_POS, error: ERR_OK};
    emit_w = '{code: em_t, position: pos_r, line_end: emit_close,
               fill_count: emit_close ? (LAST_POS - pos_r) : 7'd0, error: ERR_OK};
    push.count = 2'd0;
    push.word0 = eod_w;
    push.word1 = eod_w;
    if (eoi) begin
      if (eoi_mid) begin
        push.count = 2'd2;
        push.word0 = fail_w;
      end else if (!eod_r) begin
        push.count = 2'd1;
      end
    end else if (fail_now) begin
      push.count       = 2'd1;
      push.word0       = fail_w;
      push.word0.error = fail_err;
    end else if (emit_ok) begin
      push.count = 2'd1;
      push.word0 = emit_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      held_r <= 8'h00;
      pos_r  <= 7'd0;
      eod_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
      eod_r  <= eod_nxt;
    end
  end

endmodule

>>> sv/etmc_fifo.sv
// ----------------------------------------------------------------------------
// etmc_fifo: small result queue
// Takes up to two result words per cycle and delivers one per cycle while
// out_ready is high. Ready is raised while room for two more words remains.
// ----------------------------------------------------------------------------
module etmc_fifo
  import etmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      space_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [FIFO_AW:0] ROOM_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH - 2);

  out_word_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  assign space_ok  = (count_r <= ROOM_LIMIT);
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.word0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.word1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/escaped_text_to_machine_code.sv
// A result word enters the result queue at the edge that accepts its input word.
// Throughput: one input word per cycle while in_ready is high.
// An end-of-input word may yield two results, which leave the queue one at a time.
// The four-entry result queue lowers in_ready when fewer than two places are free.
// Reset (synchronous, rst_n low) returns the parser to plain text mode and empties
// the queue; the block accepts words as soon as reset is released.
// ----------------------------------------------------------------------------
// escaped_text_to_machine_code: text to machine code line converter
// Converts a stream of text bytes, with bracketed code sequences, into line
// records of machine character codes with position and fill count.
// ----------------------------------------------------------------------------
module escaped_text_to_machine_code
  import etmc_pkg::*;
#(
  parameter int LINE_LEN = 100
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  // A word is taken whenever the queue can absorb the worst case of two results.
  logic  in_fire;
  push_t push;

  assign in_fire = in_valid && in_ready;

  // The parser does all the work for a word in the cycle it is accepted:
  // mode decode, ROM lookups, record position and error checks.
  etmc_parse #(
    .LINE_LEN(LINE_LEN)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_word(in_data),
    .push   (push)
  );

  // The queue separates the two sides so a stalled consumer does not
  // stop the parser until the queue fills.
  etmc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> dv/etmc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// etmc_checker: result predictor and comparator for the text converter
// Watches both channels, predicts the line record words for each accepted
// input word and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module etmc_checker
  import etmc_pkg::*;
#(
  parameter int LINE_LEN = 100
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fault_count,
  output int        expected_left
);

  logic [7:0] glyph_rom   [256];
  logic [7:0] bracket_rom [256];

  mode_t      parse_q;
  logic [7:0] held_q;
  logic [6:0] line_pos_q;
  logic       closed_by_eod_q;
  out_word_t  predicted_codes [$];
  int         fault_total;

  initial begin
    for (int i = 0; i < 256; i++) begin
      glyph_rom[i]   = 8'h00;
      bracket_rom[i] = 8'h00;
    end
    glyph_rom["-"] = 8'h00;  glyph_rom["y"] = 8'h01;  glyph_rom[" "] = 8'h03;
    glyph_rom[8'h08] = 8'h13; glyph_rom["q"] = 8'h04; glyph_rom["p"] = 8'h05;
    glyph_rom["="] = 8'h06;  glyph_rom["j"] = 8'h07;  glyph_rom["/"] = 8'h09;
    glyph_rom[","] = 8'h8c;  glyph_rom["f"] = 8'h0e;  glyph_rom["g"] = 8'h0f;
    glyph_rom["w"] = 8'h10;  glyph_rom["s"] = 8'h11;  glyph_rom["i"] = 8'h14;
    glyph_rom["'"] = 8'h15;  glyph_rom["."] = 8'h96;  glyph_rom["["] = 8'h17;
    glyph_rom[8'h0a] = 8'h33; glyph_rom["o"] = 8'h19; glyph_rom[8'h09] = 8'h23;
    glyph_rom["a"] = 8'h1c;  glyph_rom["r"] = 8'h1d;  glyph_rom["v"] = 8'h1e;
    glyph_rom["m"] = 8'h1f;  glyph_rom["b"] = 8'h20;  glyph_rom["h"] = 8'h21;
    glyph_rom["k"] = 8'h24;  glyph_rom["e"] = 8'h25;  glyph_rom["n"] = 8'h26;
    glyph_rom["t"] = 8'h27;  glyph_rom["l"] = 8'h29;  glyph_rom["c"] = 8'h2c;
    glyph_rom["d"] = 8'h2d;  glyph_rom["u"] = 8'h2e;  glyph_rom["x"] = 8'h2f;
    glyph_rom["9"] = 8'h30;  glyph_rom["0"] = 8'h31;  glyph_rom["6"] = 8'h34;
    glyph_rom["5"] = 8'h35;  glyph_rom["2"] = 8'h36;  glyph_rom["z"] = 8'h37;
    glyph_rom["4"] = 8'h39;  glyph_rom["8"] = 8'h3c;  glyph_rom["7"] = 8'h3d;
    glyph_rom["3"] = 8'h3e;  glyph_rom["1"] = 8'h3f;
    glyph_rom["_"] = 8'h80;  glyph_rom["Y"] = 8'h81;  glyph_rom["Q"] = 8'h84;
    glyph_rom["P"] = 8'h85;  glyph_rom["+"] = 8'h86;  glyph_rom["J"] = 8'h87;
    glyph_rom["?"] = 8'h89;  glyph_rom[":"] = 8'h8d;  glyph_rom["F"] = 8'h8e;
    glyph_rom["G"] = 8'h8f;  glyph_rom["W"] = 8'h90;  glyph_rom["S"] = 8'h91;
    glyph_rom["|"] = 8'h92;  glyph_rom["I"] = 8'h94;  glyph_rom["\""] = 8'h95;
    glyph_rom["{"] = 8'h97;  glyph_rom["O"] = 8'h99;  glyph_rom["A"] = 8'h9c;
    glyph_rom["R"] = 8'h9d;  glyph_rom["V"] = 8'h9e;  glyph_rom["M"] = 8'h9f;
    glyph_rom["B"] = 8'ha0;  glyph_rom["H"] = 8'ha1;  glyph_rom["K"] = 8'ha4;
    glyph_rom["E"] = 8'ha5;  glyph_rom["N"] = 8'ha6;  glyph_rom["T"] = 8'ha7;
    glyph_rom["L"] = 8'ha9;  glyph_rom["C"] = 8'hac;  glyph_rom["D"] = 8'had;
    glyph_rom["U"] = 8'hae;  glyph_rom["X"] = 8'haf;  glyph_rom["("] = 8'hb0;
    glyph_rom[")"] = 8'hb1;  glyph_rom["^"] = 8'hb4;  glyph_rom["%"] = 8'hb5;
    glyph_rom["@"] = 8'hb6;  glyph_rom["Z"] = 8'hb7;  glyph_rom["$"] = 8'hb9;
    glyph_rom["*"] = 8'hbc;  glyph_rom["&"] = 8'hbd;  glyph_rom["#"] = 8'hbe;
    glyph_rom["!"] = 8'hbf;

    bracket_rom[" "] = 8'h02;   bracket_rom[8'h08] = 8'h12;
    bracket_rom[8'h09] = 8'h22; bracket_rom[8'h0a] = 8'h32;
    bracket_rom["-"] = 8'h08;   bracket_rom["w"] = 8'h18;
    bracket_rom["b"] = 8'h28;   bracket_rom["9"] = 8'h38;
    bracket_rom["/"] = 8'h0a;   bracket_rom["o"] = 8'h1a;
    bracket_rom["l"] = 8'h2a;   bracket_rom["4"] = 8'h3a;
    bracket_rom["g"] = 8'h0b;   bracket_rom["m"] = 8'h1b;
    bracket_rom["x"] = 8'h2b;   bracket_rom["1"] = 8'h3b;

    parse_q         = M_NORMAL;
    held_q          = 8'h00;
    line_pos_q      = 7'd0;
    closed_by_eod_q = 1'b0;
    fault_total     = 0;
  end

  // Escape letters fold to lower case by setting bit 5; only B, N and T match.
  function automatic logic [7:0] escape_char(input logic [7:0] e);
    case (e | 8'h20)
      "b":     return 8'h08;
      "n":     return CH_LF;
      "t":     return 8'h09;
      default: return 8'h00;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fault_total++;
  endtask

  task automatic queue_record(input logic [7:0] code, input logic [6:0] pos,
                              input logic closes, input logic [6:0] fill,
                              input logic [2:0] err);
    out_word_t w;
    w.code       = code;
    w.position   = pos;
    w.line_end   = closes;
    w.fill_count = fill;
    w.error      = err;
    predicted_codes.push_back(w);
  endtask

  task automatic restart_stream();
    parse_q         = M_NORMAL;
    held_q          = 8'h00;
    line_pos_q      = 7'd0;
    closed_by_eod_q = 1'b0;
  endtask

  // An error record closes the partial line and parks the parser until end of input.
  task automatic halt_with(input logic [2:0] err);
    queue_record(8'h00, line_pos_q, 1'b1, 7'd0, err);
    parse_q         = M_HALT;
    closed_by_eod_q = 1'b0;
    line_pos_q      = 7'd0;
    held_q          = 8'h00;
  endtask

  task automatic put_code(input logic [7:0] c, input logic [7:0] t, input logic raw_nl);
    if (c == CH_LF || t == CODE_EOD) begin
      if (c != CH_LF) begin
        halt_with(ERR_OVERFLOW);
      end else begin
        queue_record(t, line_pos_q, 1'b1, 7'(LINE_LEN - 1 - line_pos_q), ERR_OK);
        line_pos_q = 7'd0;
        parse_q    = raw_nl ? M_NORMAL : M_SKIP;
      end
    end else if (line_pos_q + 1 >= LINE_LEN) begin
      halt_with(ERR_OVERFLOW);
    end else begin
      queue_record(t, line_pos_q, 1'b0, 7'd0, ERR_OK);
      line_pos_q = line_pos_q + 7'd1;
      parse_q    = M_NORMAL;
    end
  endtask

  task automatic close_bracket(input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] t;
    logic       is_eod;
    if (b != CH_RBRK) begin
      halt_with(ERR_STRING);
    end else begin
      c      = held_q;
      t      = bracket_rom[c];
      is_eod = (c == CH_SLASH);
      if (is_eod) c = CH_LF;
      if (t == 8'h00) begin
        halt_with(ERR_UNKNOWN);
      end else begin
        held_q = 8'h00;
        put_code(c, t, 1'b0);
        if (is_eod && parse_q != M_HALT) closed_by_eod_q = 1'b1;
      end
    end
  endtask

  task automatic convert_text_word(input in_word_t w);
    logic [7:0] b;
    logic       mid_line;
    b = w.ch;
    if (w.func) begin
      mid_line = (parse_q inside {M_OPEN, M_CODE, M_BSL, M_ESC}) ||
                 (parse_q == M_NORMAL && line_pos_q != 7'd0);
      if (mid_line) halt_with(ERR_OVERFLOW);
      if (!closed_by_eod_q) queue_record(bracket_rom[CH_SLASH], 7'd0, 1'b1,
                                         7'(LINE_LEN - 1), ERR_OK);
      restart_stream();
    end else begin
      case (parse_q)
        M_NORMAL: begin
          closed_by_eod_q = 1'b0;
          if (b == CH_LBRK) parse_q = M_OPEN;
          else put_code(b, glyph_rom[b], 1'b1);
        end
        M_OPEN: begin
          if (b == CH_LF) begin
            halt_with(ERR_STRING);
          end else begin
            held_q  = b;
            parse_q = M_CODE;
          end
        end
        M_CODE: begin
          if (b == CH_BSL) parse_q = M_BSL;
          else close_bracket(b);
        end
        M_BSL: begin
          held_q = escape_char(b);
          if (held_q == 8'h00) halt_with(ERR_ESCAPE);
          else parse_q = M_ESC;
        end
        M_ESC: close_bracket(b);
        M_SKIP: begin
          if (b == CH_LF) parse_q = M_NORMAL;
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (predicted_codes.size() == 0) begin
      report_mismatch($sformatf("unexpected word code %02h position %0d error %0d",
                                got.code, got.position, got.error));
    end else begin
      want = predicted_codes.pop_front();
      if (got.code != want.code)
        report_mismatch($sformatf("code %02h, expected %02h at position %0d",
                                  got.code, want.code, want.position));
      if (got.position != want.position)
        report_mismatch($sformatf("position %0d, expected %0d",
                                  got.position, want.position));
      if (got.line_end != want.line_end)
        report_mismatch($sformatf("line_end %0d, expected %0d at position %0d",
                                  got.line_end, want.line_end, want.position));
      if (got.fill_count != want.fill_count)
        report_mismatch($sformatf("fill_count %0d, expected %0d at position %0d",
                                  got.fill_count, want.fill_count, want.position));
      if (got.error != want.error)
        report_mismatch($sformatf("error %0d, expected %0d at position %0d",
                                  got.error, want.error, want.position));
    end
  endtask

  // Results are checked before the new input word is predicted: a word accepted
  // at this edge cannot have its result on the output at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_stream();
      predicted_codes.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) convert_text_word(in_data);
    end
    fault_count   <= fault_total;
    expected_left <= predicted_codes.size();
  end

endmodule

>>> dv/tb_escaped_text_to_machine_code.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escaped_text_to_machine_code: regression bench of the text converter
// Feeds text streams, first a handful of hand-picked cases, then random
// streams of mostly well-formed lines with occasional broken sequences,
// under three idle patterns; a checker beside the block predicts every
// record word and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_escaped_text_to_machine_code;
  import etmc_pkg::*;

  localparam int LINE_LEN     = 100;
  localparam int WORD_BUDGET  = 2000;   // random input words, roughly
  localparam int CYCLE_LIMIT  = 400000; // watchdog, far above the slowest run
  localparam int DRAIN_CYCLES = 8;      // quiet time after the last result

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fault_count;
  int expected_left;
  int cycle_count = 0;
  int words_sent  = 0;

  // Percent of cycles in which the sender or the receiver holds off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Set on a deliberate break; bar a known code, the block is halted or in an
  // open bracket until end of input. Dangling brackets allow no junk after them.
  bit stream_broken;
  bit junk_ok;

  // Character sets used to build tokens. Backspace is written in octal.
  string code_chars   = " \010\t-wb9ol4gmx1";
  string tab_escapes  = "bBtT";
  string line_escapes = "nN";
  string bad_escapes  = "aqzZ0]\\[";
  string bad_closers  = "az[\t.";

  escaped_text_to_machine_code #(
    .LINE_LEN (LINE_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  etmc_checker #(
    .LINE_LEN (LINE_LEN)
  ) code_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fault_count   (fault_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether it takes a word.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Random byte helpers. Plain bytes must not open a bracket or end the line.
  function automatic logic [7:0] any_plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CH_LBRK || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] printable_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(8'h7e, 8'h20));
    end while (b == CH_LBRK);
    return b;
  endfunction

  function automatic logic [7:0] byte_not_lf();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Drives one word and returns at the edge where it is accepted. The valid is
  // only lowered for an idle cycle, so it never drops and rises in one step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(in_word_t'{func: 1'b0, ch: b});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // End of input; the byte field carries noise since the block ignores it.
  task automatic send_end();
    send_word(in_word_t'{func: 1'b1, ch: 8'($urandom_range(255))});
  endtask

  // One code of a well-formed line: a plain byte, a bracketed code or a
  // bracketed escape that does not end the line.
  task automatic send_code_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_byte(printable_byte());
    end else if (pick < 70) begin
      send_byte(any_plain_byte());
    end else if (pick < 90) begin
      send_byte(CH_LBRK);
      send_byte(pick_char(code_chars));
      send_byte(CH_RBRK);
    end else begin
      send_byte(CH_LBRK);
      send_byte(byte_not_lf());
      send_byte(CH_BSL);
      send_byte(pick_char(tab_escapes));
      send_byte(CH_RBRK);
    end
  endtask

  // A broken bracket sequence. Every kind halts the block at once but a dangling
  // bracket, left open for end of input to catch, and a known closed code.
  task automatic send_noise();
    int kind;
    kind          = $urandom_range(6);
    stream_broken = 1'b1;
    send_byte(CH_LBRK);
    case (kind)
      0: send_byte(CH_LF);
      1: begin
        send_byte(byte_not_lf());
        send_byte(CH_LF);
      end
      2: begin
        send_byte(byte_not_lf());
        send_byte(CH_BSL);
        send_byte(CH_LF);
      end
      3: begin
        send_byte(byte_not_lf());
        send_byte(CH_BSL);
        send_byte(pick_char(bad_escapes));
      end
      4: begin
        send_byte(byte_not_lf());
        send_byte(pick_char(bad_closers));
      end
      5: begin
        // Most code characters are unknown to the code table.
        send_byte(byte_not_lf());
        send_byte(CH_RBRK);
      end
      default: begin
        junk_ok = 1'b0;
        if ($urandom_range(2) > 0) send_byte(byte_not_lf());
        if ($urandom_range(1) > 0) begin
          send_byte(CH_BSL);
          if ($urandom_range(1) > 0) send_byte(pick_char(tab_escapes));
        end
      end
    endcase
  endtask

  // Rest of a source line after a coded close; the block skips it up to LF.
  task automatic send_skipped_tail(input bit last_line);
    repeat ($urandom_range(4)) send_byte(byte_not_lf());
    if (!last_line || $urandom_range(1) > 0) send_byte(CH_LF);
  endtask

  // Line lengths are mostly short; a few reach the end of the record exactly
  // or stop one code before it, and a few run one code past it.
  task automatic send_line(input bit last_line);
    int n_codes;
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) n_codes = LINE_LEN - 2 + $urandom_range(1);
    else if (pick < 5) n_codes = LINE_LEN;
    else n_codes = $urandom_range(12);
    for (int i = 0; i < n_codes && !stream_broken; i++) begin
      if ($urandom_range(99) == 0) send_noise();
      else send_code_token();
    end
    if (n_codes == LINE_LEN) stream_broken = 1'b1;
    if (!stream_broken) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_byte(CH_LF);
      end else if (pick < 8) begin
        send_byte(CH_LBRK);
        send_byte(byte_not_lf());
        send_byte(CH_BSL);
        send_byte(pick_char(line_escapes));
        send_byte(CH_RBRK);
        send_skipped_tail(last_line);
      end else if (pick < 9) begin
        send_text("[/]");
        send_skipped_tail(last_line);
      end else if (!last_line) begin
        send_byte(CH_LF);
      end
      // Otherwise the last line stays open and end of input closes it.
    end
  endtask

  task automatic send_stream();
    int n_lines;
    n_lines       = $urandom_range(1, 4);
    stream_broken = 1'b0;
    junk_ok       = 1'b1;
    for (int l = 0; l < n_lines && !stream_broken; l++) send_line(l == n_lines - 1);
    // A halted block must ignore anything up to end of input.
    if (stream_broken && junk_ok) repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
    send_end();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      // Idle patterns: slow receiver, then slow sender, then full rate.
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // Unmapped extremes, a plain glyph, a code and a tab escape.
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("a[w][x\\t]");
        // End-of-data code closes the line; the rest of the line is skipped,
        // and the end of input after it adds no second end-of-data record.
        send_text("[/]q\n");
        send_end();
        // A bad escape halts the block; end of input gives the end-of-data record.
        send_text("[a\\q");
        send_byte(8'h41);
        send_end();
        // A raw newline as the code character.
        send_text("[\n");
        send_end();
      end

      while (words_sent < (ph + 1) * WORD_BUDGET / 3) send_stream();
    end
    in_valid <= 1'b0;

    // Wait for every predicted word, then give stray words time to show up.
    do begin
      @(posedge clk);
    end while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && expected_left == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> escaped_text_to_machine_code.f
sv/etmc_pkg.sv
sv/etmc_parse.sv
sv/etmc_fifo.sv
sv/escaped_text_to_machine_code.sv
dv/etmc_checker.sv
dv/tb_escaped_text_to_machine_code.sv
